@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion helper macros for the rolling hash search block
// clocked, reset-gated wrappers around concurrent assertions
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property checked on every clock edge outside reset
`define RHSS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// same-cycle implication
`define RHSS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RHSS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/rhss_pkg.sv @@
// ----------------------------------------------------------------------------
// rhss_pkg
// shared types, constants and modular helpers for the rolling hash search
// ----------------------------------------------------------------------------
package rhss_pkg;

    localparam int DEF_MAX_PATTERN = 64;
    localparam int DEF_MAX_TEXT    = 65536;

    localparam int HASH_W   = 30;
    localparam int LETTER_W = 5;
    localparam int POS_W    = 16;

    localparam logic [HASH_W-1:0]   HASH_MOD    = 30'd1000000007;
    localparam logic [31:0]         HASH_MOD_X1 = 32'd1000000007;
    localparam logic [31:0]         HASH_MOD_X2 = 32'd2000000014;
    localparam logic [31:0]         HASH_MOD_X3 = 32'd3000000021;
    localparam logic [LETTER_W-1:0] LETTER_TOP  = 5'd25;

    // bits of the outgoing letter value, walked msb first by the multiplier
    localparam int MUL_STEPS = LETTER_W;
    localparam int MUL_CNT_W = 3;
    localparam logic [MUL_CNT_W-1:0] MUL_LAST = 3'(MUL_STEPS - 1);

    typedef enum logic [1:0] {
        OP_CLEAR   = 2'd0,
        OP_PATTERN = 2'd1,
        OP_TEXT    = 2'd2
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_PAT,
        S_READ,
        S_MUL,
        S_SUB,
        S_ROLL,
        S_CHECK,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic latch;
        logic clear;
        logic pat_step;
        logic mem_read;
        logic mul_step;
        logic sub;
        logic roll;
        logic check;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic text_open;
        logic drop_needed;
        logic mul_last;
    } t_dp_status;

    // reduce a value below four times the modulus
    function automatic logic [HASH_W-1:0] mod_reduce(input logic [31:0] x);
        logic [31:0] r;
        if (x >= HASH_MOD_X3) begin
            r = x - HASH_MOD_X3;
        end else if (x >= HASH_MOD_X2) begin
            r = x - HASH_MOD_X2;
        end else if (x >= HASH_MOD_X1) begin
            r = x - HASH_MOD_X1;
        end else begin
            r = x;
        end
        return r[HASH_W-1:0];
    endfunction

    // 3*h + v, then reduced; h below the modulus and v at most 26
    function automatic logic [HASH_W-1:0] mul3_add(input logic [HASH_W-1:0] h,
                                                  input logic [LETTER_W-1:0] v);
        logic [31:0] s;
        s = (32'(h) << 1) + 32'(h) + 32'(v);
        return mod_reduce(s);
    endfunction

endpackage

@@ rtl/rhss_ctrl.sv @@
// ----------------------------------------------------------------------------
// rhss_ctrl
// sequencer for the rolling hash search: steps one item through the datapath
// and owns both channel handshakes
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rhss_ctrl import rhss_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_op,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   in_xfer;
    logic   out_free;

    assign in_xfer  = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    case (i_op)
                        OP_CLEAR:   n_state = S_CLEAR;
                        OP_PATTERN: n_state = S_PAT;
                        OP_TEXT: begin
                            if (!i_status.text_open) begin
                                n_state = S_EMIT;
                            end else if (i_status.drop_needed) begin
                                n_state = S_READ;
                            end else begin
                                n_state = S_ROLL;
                            end
                        end
                        default:    n_state = S_EMIT;
                    endcase
                end
            end
            S_CLEAR: n_state = S_EMIT;
            S_PAT:   n_state = S_EMIT;
            S_READ:  n_state = S_MUL;
            S_MUL: begin
                if (i_status.mul_last) begin
                    n_state = S_SUB;
                end
            end
            S_SUB:   n_state = S_ROLL;
            S_ROLL:  n_state = S_CHECK;
            S_CHECK: n_state = S_EMIT;
            S_EMIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd          = '0;
        o_cmd.latch    = in_xfer;
        o_cmd.clear    = (r_state == S_CLEAR);
        o_cmd.pat_step = (r_state == S_PAT);
        o_cmd.mem_read = (r_state == S_READ);
        o_cmd.mul_step = (r_state == S_MUL);
        o_cmd.sub      = (r_state == S_SUB);
        o_cmd.roll     = (r_state == S_ROLL);
        o_cmd.check    = (r_state == S_CHECK);
        o_cmd.load_out = (r_state == S_EMIT) && out_free;
    end

    always_comb begin
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    `RHSS_ASSERT_NXT(a_emit_lands, i_clk, i_rst_n, (r_state == S_EMIT) && out_free, r_out_valid && (r_state == S_IDLE), "result not presented after emit")
    `RHSS_ASSERT_NXT(a_read_to_mul, i_clk, i_rst_n, r_state == S_READ, r_state == S_MUL, "read not followed by multiply")
    `RHSS_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, o_cmd.load_out && r_out_valid, !i_out_stall, "pending result overwritten")

endmodule

@@ rtl/rhss_dp.sv @@
// ----------------------------------------------------------------------------
// rhss_dp
// hash datapath: pattern hash and power, rolling window hash with an
// iterative multiply-mod for the outgoing letter, letter store, match tracking
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rhss_dp import rhss_pkg::*; #(
    parameter int MAX_PATTERN = DEF_MAX_PATTERN,
    parameter int MAX_TEXT    = DEF_MAX_TEXT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [LETTER_W-1:0] i_letter,
    input  t_dp_cmd             i_cmd,
    output t_dp_status          o_status,
    output logic [HASH_W-1:0]   o_window_hash,
    output logic                o_is_match,
    output logic [POS_W-1:0]    o_match_start,
    output logic                o_first_found,
    output logic [POS_W-1:0]    o_first_position
);

    localparam int LW = $clog2(MAX_PATTERN + 1);
    localparam int TW = $clog2(MAX_TEXT + 1);
    localparam int PW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int CW = (LW > TW) ? LW : TW;

    logic [HASH_W-1:0]   r_pattern_hash,   n_pattern_hash;
    logic [LW-1:0]       r_pattern_length, n_pattern_length;
    logic [HASH_W-1:0]   r_top_power,      n_top_power;
    logic [HASH_W-1:0]   r_window_hash,    n_window_hash;
    logic [TW-1:0]       r_text_count,     n_text_count;
    logic [PW-1:0]       r_wr_ptr,         n_wr_ptr;
    logic                r_found,          n_found;
    logic [POS_W-1:0]    r_first_start,    n_first_start;
    logic                r_match,          n_match;
    logic [POS_W-1:0]    r_start,          n_start;
    logic [LETTER_W-1:0] r_letter;
    logic [LETTER_W-1:0] r_rd_data;
    logic [HASH_W-1:0]   r_acc;
    logic [MUL_CNT_W-1:0] r_mul_cnt;

    logic [LETTER_W-1:0] mem [MAX_PATTERN];

    logic [CW-1:0]       tc_ext;
    logic [CW-1:0]       len_ext;
    logic                pat_open;
    logic                window_full;
    logic [LW:0]         rd_sum;
    logic [LW:0]         rd_mod;
    logic [PW-1:0]       rd_addr;
    logic [LETTER_W-1:0] val;
    logic [LETTER_W-1:0] old_val;
    logic                mul_bit;
    logic [31:0]         mul_sum;
    logic [HASH_W:0]     sub_wrap;
    logic [HASH_W-1:0]   sub_res;
    logic [CW-1:0]       start_diff;
    logic [CW+POS_W-1:0] start_ext;

    assign tc_ext      = CW'(r_text_count);
    assign len_ext     = CW'(r_pattern_length);
    assign window_full = (r_pattern_length != '0) && (tc_ext >= len_ext);
    assign pat_open    = (r_text_count == '0) && (r_pattern_length < LW'(MAX_PATTERN));

    assign o_status.text_open   = (r_text_count < TW'(MAX_TEXT));
    assign o_status.drop_needed = window_full;
    assign o_status.mul_last    = (r_mul_cnt == MUL_LAST);

    // slot of the letter leaving the window: (wr_ptr - length) mod depth
    assign rd_sum  = (LW+1)'(r_wr_ptr) + (LW+1)'(MAX_PATTERN) - (LW+1)'(r_pattern_length);
    assign rd_mod  = (rd_sum >= (LW+1)'(MAX_PATTERN)) ? rd_sum - (LW+1)'(MAX_PATTERN) : rd_sum;
    assign rd_addr = rd_mod[PW-1:0];

    assign val     = r_letter + 5'd1;
    assign old_val = r_rd_data + 5'd1;

    // shift-add multiply of letter value by top power, msb first, mod each step
    assign mul_bit = old_val[3'(MUL_LAST - r_mul_cnt)];
    assign mul_sum = (32'(r_acc) << 1) + (mul_bit ? 32'(r_top_power) : 32'd0);

    assign sub_wrap = (HASH_W+1)'(r_window_hash) + (HASH_W+1)'(HASH_MOD)
                      - (HASH_W+1)'(r_acc);
    assign sub_res  = (r_window_hash >= r_acc) ? (r_window_hash - r_acc)
                                               : sub_wrap[HASH_W-1:0];

    assign start_diff = tc_ext - len_ext;
    assign start_ext  = {{POS_W{1'b0}}, start_diff};

    always_comb begin
        n_pattern_hash   = r_pattern_hash;
        n_pattern_length = r_pattern_length;
        n_top_power      = r_top_power;
        n_window_hash    = r_window_hash;
        n_text_count     = r_text_count;
        n_wr_ptr         = r_wr_ptr;
        n_found          = r_found;
        n_first_start    = r_first_start;
        n_match          = r_match;
        n_start          = r_start;
        if (i_cmd.latch) begin
            n_match = 1'b0;
            n_start = '0;
        end
        if (i_cmd.clear) begin
            n_pattern_hash   = '0;
            n_pattern_length = '0;
            n_top_power      = HASH_W'(1);
            n_window_hash    = '0;
            n_text_count     = '0;
            n_wr_ptr         = '0;
            n_found          = 1'b0;
            n_first_start    = '0;
        end
        if (i_cmd.pat_step && pat_open) begin
            if (r_pattern_length != '0) begin
                n_top_power = mul3_add(r_top_power, '0);
            end
            n_pattern_hash   = mul3_add(r_pattern_hash, val);
            n_pattern_length = r_pattern_length + LW'(1);
        end
        if (i_cmd.sub) begin
            n_window_hash = sub_res;
        end
        if (i_cmd.roll) begin
            n_window_hash = mul3_add(r_window_hash, val);
            n_text_count  = r_text_count + TW'(1);
            n_wr_ptr      = (r_wr_ptr == PW'(MAX_PATTERN - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (i_cmd.check && window_full) begin
            n_start = start_ext[POS_W-1:0];
            if (r_window_hash == r_pattern_hash) begin
                n_match = 1'b1;
                if (!r_found) begin
                    n_found       = 1'b1;
                    n_first_start = start_ext[POS_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_hash   <= '0;
            r_pattern_length <= '0;
            r_top_power      <= HASH_W'(1);
            r_window_hash    <= '0;
            r_text_count     <= '0;
            r_wr_ptr         <= '0;
            r_found          <= 1'b0;
            r_first_start    <= '0;
            r_match          <= 1'b0;
            r_start          <= '0;
        end else begin
            r_pattern_hash   <= n_pattern_hash;
            r_pattern_length <= n_pattern_length;
            r_top_power      <= n_top_power;
            r_window_hash    <= n_window_hash;
            r_text_count     <= n_text_count;
            r_wr_ptr         <= n_wr_ptr;
            r_found          <= n_found;
            r_first_start    <= n_first_start;
            r_match          <= n_match;
            r_start          <= n_start;
        end
    end

    // letter clamp, multiplier and output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_letter <= (i_letter > LETTER_TOP) ? LETTER_TOP : i_letter;
        end
        if (i_cmd.mem_read) begin
            r_acc     <= '0;
            r_mul_cnt <= '0;
        end else if (i_cmd.mul_step) begin
            r_acc     <= mod_reduce(mul_sum);
            r_mul_cnt <= r_mul_cnt + MUL_CNT_W'(1);
        end
        if (i_cmd.load_out) begin
            o_window_hash    <= r_window_hash;
            o_is_match       <= r_match;
            o_match_start    <= r_start;
            o_first_found    <= r_found;
            o_first_position <= r_first_start;
        end
    end

    // recent text letter store
    always_ff @(posedge i_clk) begin
        if (i_cmd.roll) begin
            mem[r_wr_ptr] <= r_letter;
        end
        if (i_cmd.mem_read) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    `RHSS_ASSERT(a_window_in_range, i_clk, i_rst_n, r_window_hash < HASH_MOD, "window hash not reduced")
    `RHSS_ASSERT(a_power_in_range, i_clk, i_rst_n, (r_top_power < HASH_MOD) && (r_top_power != '0), "top power out of range")
    `RHSS_ASSERT_IMP(a_found_needs_window, i_clk, i_rst_n, r_found, (r_pattern_length != '0) && (tc_ext >= len_ext), "match flagged without a full window")

endmodule

@@ rtl/rolling_hash_substring_search_unit.sv @@
// ----------------------------------------------------------------------------
// rolling_hash_substring_search_unit
// rolling hash substring search over lower-case letters, base 3, mod 1e9+7
// ----------------------------------------------------------------------------
// input channel: i_in_valid / o_in_stall carry an op (clear, pattern letter,
// text letter) and a letter index; a transfer happens when valid is high and
// stall is low. every input transfer yields exactly one result on the output
// channel o_out_valid / i_out_stall: window hash, match flag and start, and
// the first match position since the last clear.
// one item is taken at a time, in idle. a clear or pattern letter passes
// through its own state before emit; an unused op or a text letter past the
// text limit goes straight to emit; a text letter runs roll and check, and once
// the window is full it first reads the outgoing letter, forms that letter's
// term with a 5-step shift-add multiply-mod and subtracts it from the hash.
// the output register holds a finished result while the receiver stalls; the
// next item is still taken and runs until its own result is ready to load.
// reset (synchronous, active low) clears the search state; the letter store
// is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module rolling_hash_substring_search_unit import rhss_pkg::*; #(
    parameter int MAX_PATTERN = DEF_MAX_PATTERN,
    parameter int MAX_TEXT    = DEF_MAX_TEXT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [1:0]          i_op,
    input  logic [LETTER_W-1:0] i_letter,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [HASH_W-1:0]   o_window_hash,
    output logic                o_is_match,
    output logic [POS_W-1:0]    o_match_start,
    output logic                o_first_found,
    output logic [POS_W-1:0]    o_first_position
);

    t_dp_cmd    cmd;
    t_dp_status status;

    rhss_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_op        (i_op),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    rhss_dp #(
        .MAX_PATTERN (MAX_PATTERN),
        .MAX_TEXT    (MAX_TEXT)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_letter         (i_letter),
        .i_cmd            (cmd),
        .o_status         (status),
        .o_window_hash    (o_window_hash),
        .o_is_match       (o_is_match),
        .o_match_start    (o_match_start),
        .o_first_found    (o_first_found),
        .o_first_position (o_first_position)
    );

endmodule
